### rtl/core/negacyclic_monomial_multiply_top_macros.svh
// ----------------------------------------------------------------------------
// negacyclic monomial multiply assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef NEGACYCLIC_MONOMIAL_MULTIPLY_TOP_MACROS_SVH
`define NEGACYCLIC_MONOMIAL_MULTIPLY_TOP_MACROS_SVH

// same-cycle implication
`define NMM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/nmm_pkg.sv
// ----------------------------------------------------------------------------
// nmm_pkg
// shared widths, codes and the pipeline side-band type
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nmm_pkg;

  // field widths fixed by the interface
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int ROT_W = 11;

  // default polynomial size
  localparam int POLY_SIZE_DEF = 1024;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // read transaction info that travels alongside the memory read
  typedef struct packed {
    logic             valid;
    logic             in_range;
    logic             neg;
    logic             sub;
    logic [IDX_W-1:0] idx;
  } nmm_side_t;

endpackage

### rtl/core/nmm_ram.sv
// ----------------------------------------------------------------------------
// nmm_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/core/nmm_addr.sv
// ----------------------------------------------------------------------------
// nmm_addr
// input register, rotation reduction modulo 2N and memory address generation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmm_addr import nmm_pkg::*; #(
  parameter int POLY_SIZE = POLY_SIZE_DEF,
  localparam int AW = (POLY_SIZE > 1) ? $clog2(POLY_SIZE) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    take,
  input  logic                    action,
  input  logic [IDX_W-1:0]        coef_index,
  input  logic signed [VAL_W-1:0] coef_value,
  input  logic [ROT_W-1:0]        rot_amount,
  input  logic                    subtract_source,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [VAL_W-1:0]        mem_wdata,
  output logic [AW-1:0]           mem_raddr_a,
  output logic [AW-1:0]           mem_raddr_b,
  output nmm_side_t               side
);

  localparam int MODV  = 2 * POLY_SIZE;
  localparam int SPLIT = 5;
  localparam int ROT_LIM = 2 ** ROT_W;

  // stage 1 registers
  logic             s1_valid;
  logic             s1_action;
  logic [IDX_W-1:0] s1_idx;
  logic [VAL_W-1:0] s1_val;
  logic [ROT_W-1:0] s1_rot;
  logic             s1_sub;

  // stage 2 registers
  logic             s2_valid;
  logic             s2_action;
  logic [IDX_W-1:0] s2_idx;
  logic [VAL_W-1:0] s2_val;
  logic [ROT_W-1:0] s2_rot;
  logic             s2_sub;

  logic [ROT_W-1:0] rot_hi;
  logic [ROT_W-1:0] rot_lo;
  logic [ROT_W-1:0] rot_a;
  logic             neg;
  logic             in_range;
  logic [AW-1:0]    src;

  // upper conditional subtractions of 2N * 2^k
  always_comb begin
    rot_hi = s1_rot;
    for (int k = ROT_W - 1; k >= SPLIT; k--) begin
      if ((MODV << k) < ROT_LIM) begin
        if (rot_hi >= ROT_W'(MODV << k)) begin
          rot_hi = rot_hi - ROT_W'(MODV << k);
        end
      end
    end
  end

  // lower conditional subtractions finish the modulo
  always_comb begin
    rot_lo = s2_rot;
    for (int k = SPLIT - 1; k >= 0; k--) begin
      if ((MODV << k) < ROT_LIM) begin
        if (rot_lo >= ROT_W'(MODV << k)) begin
          rot_lo = rot_lo - ROT_W'(MODV << k);
        end
      end
    end
  end

  // fold rotation into [0, N) and find source position, tracking sign
  always_comb begin
    rot_a = rot_lo;
    neg   = 1'b0;
    if (32'(rot_lo) >= POLY_SIZE) begin
      rot_a = rot_lo - ROT_W'(POLY_SIZE);
      neg   = 1'b1;
    end
    in_range = (32'(s2_idx) < POLY_SIZE);
    if (32'(s2_idx) < 32'(rot_a)) begin
      src = AW'(32'(s2_idx) + POLY_SIZE - 32'(rot_a));
      neg = !neg;
    end else begin
      src = AW'(32'(s2_idx) - 32'(rot_a));
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_action <= action;
      s1_idx    <= coef_index;
      s1_val    <= $unsigned(coef_value);
      s1_rot    <= rot_amount;
      s1_sub    <= subtract_source;
      s2_action <= s1_action;
      s2_idx    <= s1_idx;
      s2_val    <= s1_val;
      s2_rot    <= rot_hi;
      s2_sub    <= s1_sub;
    end
  end

  // memory command; writes and reads issue here in transaction order
  assign mem_we      = en && s2_valid && (s2_action == ACT_WRITE) && in_range;
  assign mem_waddr   = AW'(s2_idx);
  assign mem_wdata   = s2_val;
  assign mem_raddr_a = src;
  assign mem_raddr_b = AW'(s2_idx);

  // side-band for the read result stage
  assign side.valid    = s2_valid && (s2_action == ACT_READ);
  assign side.in_range = in_range;
  assign side.neg      = neg;
  assign side.sub      = s2_sub;
  assign side.idx      = s2_idx;

endmodule

### rtl/core/nmm_out.sv
// ----------------------------------------------------------------------------
// nmm_out
// combines read data into the output coefficient and holds the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmm_out import nmm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  nmm_side_t               side_in,
  input  logic [VAL_W-1:0]        rd_a,
  input  logic [VAL_W-1:0]        rd_b,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_value,
  output logic [IDX_W-1:0]        out_index
);

  nmm_side_t        s3;
  logic [VAL_W-1:0] res;

  // side-band aligned with the registered memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (en) begin
      s3.valid <= side_in.valid;
    end
    if (en) begin
      s3.in_range <= side_in.in_range;
      s3.neg      <= side_in.neg;
      s3.sub      <= side_in.sub;
      s3.idx      <= side_in.idx;
    end
  end

  // signed rotation term minus optional source term, all modulo 2^32; zero for an out-of-range index
  always_comb begin
    res = s3.neg ? (VAL_W'(0) - rd_a) : rd_a;
    if (s3.sub) begin
      res = res - rd_b;
    end
    if (!s3.in_range) begin
      res = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= $signed(res);
      out_index <= s3.idx;
    end
  end

endmodule

### rtl/core/negacyclic_monomial_multiply_top.sv
// ----------------------------------------------------------------------------
// negacyclic_monomial_multiply_top
// a read transaction passes the input register, stage 2, the memory read and the output register
// throughput: one transaction per cycle while the output is not stalled,
// set by one pass through the dual-read coefficient memory per transaction
// reset clears pipeline valids only; coefficient memory is undefined until written
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "negacyclic_monomial_multiply_top_macros.svh"

module negacyclic_monomial_multiply_top import nmm_pkg::*; #(
  parameter int POLY_SIZE = POLY_SIZE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic [IDX_W-1:0]        coef_index,
  input  logic signed [VAL_W-1:0] coef_value,
  input  logic [ROT_W-1:0]        rot_amount,
  input  logic                    subtract_source,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_value,
  output logic [IDX_W-1:0]        out_index
);

  localparam int AW = (POLY_SIZE > 1) ? $clog2(POLY_SIZE) : 1;

  logic             pipe_en;
  logic             take;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr_a;
  logic [AW-1:0]    mem_raddr_b;
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;
  nmm_side_t        side;

  // whole pipeline advances unless a finished result is held
  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;
  assign take     = in_valid && pipe_en;

  // address and rotation stages
  nmm_addr #(
    .POLY_SIZE(POLY_SIZE)
  ) u_addr (
    .clk             (clk),
    .rst             (rst),
    .en              (pipe_en),
    .take            (take),
    .action          (action),
    .coef_index      (coef_index),
    .coef_value      (coef_value),
    .rot_amount      (rot_amount),
    .subtract_source (subtract_source),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr_a     (mem_raddr_a),
    .mem_raddr_b     (mem_raddr_b),
    .side            (side)
  );

  // coefficient memory
  nmm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(POLY_SIZE)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (pipe_en),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // result stage and output register
  nmm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .side_in   (side),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_index (out_index)
  );

  // checks
  `NMM_ASSERT_IMPL(a_write_only_when_moving, clk, rst, mem_we, pipe_en, "memory write while stalled")
  `NMM_ASSERT_IMPL(a_src_in_range, clk, rst, side.valid && side.in_range, 32'(mem_raddr_a) < POLY_SIZE, "rotated source address out of range")
  `NMM_ASSERT_IMPL(a_out_of_range_zero, clk, rst, out_valid && (32'(out_index) >= POLY_SIZE), out_value == 0, "out-of-range read gave nonzero value")
  `NMM_ASSERT_NEXT(a_held_result_kept, clk, rst, out_valid && out_stall, out_valid && in_stall == out_stall, "held result dropped")

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the negacyclic monomial multiplier with a directed opening and then
// random write/read traffic. Reads only touch coefficients already written.
// A mirrored coefficient store predicts each rotated or differenced
// coefficient. Both sides idle and stall at random, the receiver holds off
// once for a long stretch, and the sender pauses once until the block drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import nmm_pkg::*;

  localparam int POLY = POLY_SIZE_DEF;

  // expected coefficients and the mirrored source polynomial
  class monomial_product_checker;
    typedef struct {
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] index;
    } coef_t;

    bit [VAL_W-1:0] source_mirror [POLY];
    coef_t          expected_coefs [$];
    int             mismatches;

    function new();
      mismatches = 0;
      foreach (source_mirror[i]) source_mirror[i] = '0;
    endfunction

    // coefficient idx of X^rot * source, minus source when sub is set
    function bit [VAL_W-1:0] product_coef(int unsigned idx, int unsigned rot, bit sub);
      int unsigned    shift;
      int unsigned    src;
      bit             flip;
      bit [VAL_W-1:0] v;
      if (idx >= POLY) return '0;
      shift = rot % (2 * POLY);
      flip  = 1'b0;
      if (shift >= POLY) begin
        shift = shift - POLY;
        flip  = 1'b1;
      end
      // wrapping past X^N changes sign
      if (idx < shift) begin
        src  = idx + POLY - shift;
        flip = !flip;
      end else begin
        src = idx - shift;
      end
      v = source_mirror[src];
      if (flip) v = -v;
      if (sub) v = v - source_mirror[idx];
      return v;
    endfunction

    // accepted input transaction
    function void note_transaction(bit act, bit [IDX_W-1:0] idx, bit [VAL_W-1:0] val,
                                   bit [ROT_W-1:0] rot, bit sub);
      coef_t c;
      if (act == ACT_WRITE) begin
        if (idx < POLY) source_mirror[idx] = val;
        return;
      end
      c.value = product_coef(idx, rot, sub);
      c.index = idx;
      expected_coefs.push_back(c);
    endfunction

    task report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      mismatches++;
    endtask

    // accepted output transaction against the oldest expectation
    task check_coef(logic [VAL_W-1:0] value, logic [IDX_W-1:0] index);
      coef_t want;
      if (expected_coefs.size() == 0) begin
        report_mismatch("unexpected result, value", value, 'x);
        return;
      end
      want = expected_coefs.pop_front();
      if (value !== want.value) report_mismatch("out_value", value, want.value);
      if (index !== want.index) report_mismatch("out_index", index, want.index);
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    action;
  logic [IDX_W-1:0]        coef_index;
  logic signed [VAL_W-1:0] coef_value;
  logic [ROT_W-1:0]        rot_amount;
  logic                    subtract_source;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_value;
  logic [IDX_W-1:0]        out_index;

  monomial_product_checker board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;

  // which source coefficients may be read
  bit written_map [POLY];
  int written_list [$];

  negacyclic_monomial_multiply_top #(.POLY_SIZE(POLY)) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .coef_index      (coef_index),
    .coef_value      (coef_value),
    .rot_amount      (rot_amount),
    .subtract_source (subtract_source),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_index       (out_index)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("tb_top failed");
    $finish;
  end

  // receiver stall, with one long hold-off on request
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) board.check_coef(out_value, out_index);
  end

  // offer one transaction and wait until it is taken
  task send_item(input bit act, input bit [IDX_W-1:0] idx, input bit [VAL_W-1:0] val,
                 input bit [ROT_W-1:0] rot, input bit sub);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= act;
    coef_index      <= idx;
    coef_value      <= val;
    rot_amount      <= rot;
    subtract_source <= sub;
    if (act == ACT_WRITE && !written_map[idx]) begin
      written_map[idx] = 1'b1;
      written_list.push_back(idx);
    end
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_transaction(act, idx, val, rot, sub);
  endtask

  // random write, or a read whose source entries are all written
  task send_random;
    int          idx;
    int          src;
    int unsigned val;
    if (written_list.size() < 4 || $urandom_range(99) < 35) begin
      val = $urandom();
      case ($urandom_range(15))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'hFFFF_FFFF;
        3: val = 32'h0000_0000;
        default: ;
      endcase
      send_item(ACT_WRITE, IDX_W'($urandom_range(POLY - 1)), val,
                ROT_W'($urandom()), 1'($urandom()));
    end else begin
      idx = written_list[$urandom_range(written_list.size() - 1)];
      src = written_list[$urandom_range(written_list.size() - 1)];
      send_item(ACT_READ, IDX_W'(idx), $urandom(),
                ROT_W'((idx - src + POLY) % POLY + POLY * $urandom_range(1)),
                1'($urandom()));
    end
  endtask

  task drain_results;
    while (board.expected_coefs.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    rst             = 1'b1;
    in_valid        = 1'b0;
    action          = ACT_WRITE;
    coef_index      = '0;
    coef_value      = '0;
    rot_amount      = '0;
    subtract_source = 1'b0;
    foreach (written_map[i]) written_map[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 65;

    // directed: field extremes, wraps, sign flips, rotations past N
    send_item(ACT_WRITE, 0,    32'h7FFF_FFFF, 0,    0);
    send_item(ACT_WRITE, 1023, 32'h8000_0000, 2047, 1);
    send_item(ACT_WRITE, 512,  32'hFFFF_FFFF, 0,    0);
    send_item(ACT_WRITE, 1,    32'h0000_0001, 0,    0);
    send_item(ACT_READ,  0,    0,             0,    0);
    send_item(ACT_READ,  1023, 32'hFFFF_FFFF, 0,    0);
    send_item(ACT_READ,  0,    0,             1,    0);
    send_item(ACT_READ,  1023, 0,             1023, 0);
    send_item(ACT_READ,  0,    0,             1024, 0);
    send_item(ACT_READ,  0,    0,             2047, 1);
    send_item(ACT_READ,  1,    0,             1025, 1);
    send_item(ACT_READ,  512,  0,             512,  1);
    send_item(ACT_READ,  1023, 0,             1535, 1);
    send_item(ACT_READ,  512,  0,             1536, 1);
    send_item(ACT_READ,  0,    0,             0,    1);
    // read right behind the write it depends on
    send_item(ACT_WRITE, 700,  32'h1234_5678, 0,    0);
    send_item(ACT_READ,  700,  0,             0,    1);
    send_item(ACT_READ,  700,  0,             0,    0);
    send_item(ACT_WRITE, 0,    32'h0000_0000, 0,    0);
    send_item(ACT_READ,  1,    0,             1,    1);
    send_item(ACT_READ,  700,  0,             1724, 0);

    repeat (300) send_random();

    // sender pause until the block has drained
    in_valid <= 1'b0;
    drain_results();

    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    repeat (60) send_random();

    send_idle_pct = 65;
    recv_idle_pct = 25;
    repeat (280) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (280) send_random();

    in_valid <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
